// ===== src/sqltp_pkg.sv =====
// Shared token codes, result codes and the classified token type of the SQL token parser.
package sqltp_pkg;

	localparam int MAX_TOKENS  = 4096;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [4:0] K_OTHER    = 5'd0;
	localparam logic [4:0] K_EOF      = 5'd1;
	localparam logic [4:0] K_IDENT    = 5'd2;
	localparam logic [4:0] K_STRING   = 5'd3;
	localparam logic [4:0] K_SELECT   = 5'd4;
	localparam logic [4:0] K_INSERT   = 5'd5;
	localparam logic [4:0] K_UPDATE   = 5'd6;
	localparam logic [4:0] K_DELETE   = 5'd7;
	localparam logic [4:0] K_CREATE   = 5'd8;
	localparam logic [4:0] K_FROM     = 5'd9;
	localparam logic [4:0] K_WHERE    = 5'd10;
	localparam logic [4:0] K_INTO     = 5'd11;
	localparam logic [4:0] K_VALUES   = 5'd12;
	localparam logic [4:0] K_SET      = 5'd13;
	localparam logic [4:0] K_DATABASE = 5'd14;
	localparam logic [4:0] K_TABLE    = 5'd15;
	localparam logic [4:0] K_INT      = 5'd16;
	localparam logic [4:0] K_VARCHAR  = 5'd17;
	localparam logic [4:0] K_NOTNULL  = 5'd18;
	localparam logic [4:0] K_STAR     = 5'd19;
	localparam logic [4:0] K_EQ       = 5'd20;
	localparam logic [4:0] K_LP       = 5'd21;
	localparam logic [4:0] K_RP       = 5'd22;
	localparam logic [4:0] K_COMMA    = 5'd23;

	localparam logic [3:0] QT_NONE     = 4'hF;
	localparam logic [3:0] QT_SELECT   = 4'd0;
	localparam logic [3:0] QT_INSERT   = 4'd1;
	localparam logic [3:0] QT_DELETE   = 4'd2;
	localparam logic [3:0] QT_UPDATE   = 4'd3;
	localparam logic [3:0] QT_CREATEDB = 4'd4;
	localparam logic [3:0] QT_CREATETB = 4'd5;

	localparam logic [3:0] ERR_NONE        = 4'd0;
	localparam logic [3:0] ERR_STAR        = 4'd1;
	localparam logic [3:0] ERR_FROM        = 4'd2;
	localparam logic [3:0] ERR_TABLE       = 4'd3;
	localparam logic [3:0] ERR_KEY_VALUE   = 4'd4;
	localparam logic [3:0] ERR_EQ          = 4'd5;
	localparam logic [3:0] ERR_KEY_WORD    = 4'd6;
	localparam logic [3:0] ERR_INTO        = 4'd7;
	localparam logic [3:0] ERR_VALUES      = 4'd8;
	localparam logic [3:0] ERR_DB_NAME     = 4'd9;
	localparam logic [3:0] ERR_CREATE_KIND = 4'd10;
	localparam logic [3:0] ERR_UNKNOWN_CMD = 4'd11;

	localparam logic [1:0] COLT_UNSET   = 2'd0;
	localparam logic [1:0] COLT_INT     = 2'd1;
	localparam logic [1:0] COLT_VARCHAR = 2'd2;

	localparam logic REC_COLUMN = 1'b0;
	localparam logic REC_QUERY  = 1'b1;

	typedef struct packed {
		logic [4:0]  kind;
		logic        eof;
		logic        ident;
		logic        value;
		logic        key_word;
		logic        val_word;
		logic [11:0] pos;
	} tok_t;

endpackage

// ===== src/sqltp_if.sv =====
// Valid/ready channel interfaces for tokens in and parse records out.
interface sqltp_tok_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic        is_word_key;
	logic        is_word_val;
	logic [11:0] token_pos;

	modport source(output valid, token_kind, is_word_key, is_word_val, token_pos, input ready);
	modport sink(input valid, token_kind, is_word_key, is_word_val, token_pos, output ready);
endinterface

interface sqltp_rec_if;
	logic               valid;
	logic               ready;
	logic               record_kind;
	logic signed [3:0]  query_type;
	logic [3:0]         error_code;
	logic [11:0]        table_pos;
	logic [11:0]        key_pos;
	logic [11:0]        val_pos;
	logic [2:0]         present_mask;
	logic [7:0]         column_count;
	logic [11:0]        column_name_pos;
	logic [1:0]         column_type;
	logic               column_not_null;
	logic               last;

	modport source(output valid, record_kind, query_type, error_code, table_pos, key_pos,
		val_pos, present_mask, column_count, column_name_pos, column_type,
		column_not_null, last, input ready);
	modport sink(input valid, record_kind, query_type, error_code, table_pos, key_pos,
		val_pos, present_mask, column_count, column_name_pos, column_type,
		column_not_null, last, output ready);
endinterface

// ===== src/sql_statement_token_parser.sv =====
// Top level of the SQL statement token parser: token intake queue feeding the grammar engine.
// The parser takes one lexed token per cycle while its queue has room and follows SELECT,
// INSERT, UPDATE, DELETE and CREATE statements. Accepted tokens enter a four-entry queue; the
// grammar engine resolves the whole chain of grammar checks for the token at the queue head
// combinationally, so a token that causes no record never waits to leave the queue, and one
// that causes records leaves it once the output register is free. Records are registered. A
// token that completes a column and ends the statement at once gives two records and holds the
// output register for two transfers, column record first. The query record is sent on EOF,
// after which the grammar restarts from the command keyword.
module sql_statement_token_parser (
	input  logic        clk,
	input  logic        arst_n,
	sqltp_tok_if.sink   tokens,
	sqltp_rec_if.source records
);

	logic            head_valid;
	sqltp_pkg::tok_t head;
	logic            pop;

	sqltp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tokens     (tokens),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	sqltp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.records    (records)
	);

endmodule

// ===== src/sqltp_front.sv =====
// Token intake: classifies each accepted token and holds it in a short queue for the grammar engine.
module sqltp_front (
	input  logic               clk,
	input  logic               arst_n,
	sqltp_tok_if.sink          tokens,
	input  logic               pop,
	output logic               head_valid,
	output sqltp_pkg::tok_t    head
);

	localparam int DEPTH = sqltp_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	sqltp_pkg::tok_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	sqltp_pkg::tok_t cls;
	logic            push;
	logic            do_pop;

	always_comb begin
		cls.kind = (tokens.token_kind > sqltp_pkg::K_COMMA) ? sqltp_pkg::K_OTHER : tokens.token_kind;
		cls.eof = (cls.kind == sqltp_pkg::K_EOF);
		cls.ident = (cls.kind == sqltp_pkg::K_IDENT);
		cls.value = cls.ident || (cls.kind == sqltp_pkg::K_STRING);
		cls.key_word = cls.ident && tokens.is_word_key;
		cls.val_word = cls.ident && tokens.is_word_val;
		cls.pos = 12'({1'b0, tokens.token_pos} % 13'(sqltp_pkg::MAX_TOKENS));
	end

	assign tokens.ready = (count_q != CW'(DEPTH));
	assign push = tokens.valid && tokens.ready;
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/sqltp_back.sv =====
// Grammar engine: walks the SQL grammar for the queued token and registers the resulting records.
module sqltp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  sqltp_pkg::tok_t    head,
	output logic               pop,
	sqltp_rec_if.source        records
);

	localparam int CHAIN_STEPS = 7;

	typedef enum logic [5:0] {
		G_CMD, G_SEL_STAR, G_SEL_FROM, G_SEL_TABLE, G_SEL_WHERE, G_SW_KEY, G_SW_EQ, G_SW_VAL,
		G_INS_INTO, G_INS_TABLE, G_INS_COLS, G_INS_SKIP, G_INS_VALUES, G_INS_LP, G_INS_KEY,
		G_INS_COMMA, G_INS_VAL, G_INS_RP,
		G_UPD_TABLE, G_UPD_SET, G_US_WORD, G_US_EQ, G_US_VAL,
		G_DEL_FROM, G_DEL_TABLE,
		G_WHERE, G_W_KEY, G_W_EQ, G_W_VAL,
		G_CR_KIND, G_CR_DB, G_CT_NAME, G_CT_LP, G_CT_COL, G_CT_TYPE, G_CT_VLP, G_CT_VSIZE,
		G_CT_VRP, G_CT_NN, G_CT_COMMA, G_CT_RP,
		G_DONE
	} gstate_t;

	typedef struct packed {
		logic [3:0]  qtype;
		logic [3:0]  err;
		logic [11:0] tpos;
		logic [11:0] kpos;
		logic [11:0] vpos;
		logic [2:0]  present;
		logic [7:0]  cols;
	} kept_t;

	typedef struct packed {
		logic [11:0] name;
		logic [1:0]  ctype;
		logic        nn;
	} col_t;

	typedef struct packed {
		gstate_t gs;
		kept_t   k;
		col_t    pend;
	} ctx_t;

	typedef struct packed {
		ctx_t c;
		col_t col;
		logic fire;
		logic took;
	} step_t;

	localparam ctx_t CTX_RESET = '{
		gs: G_CMD,
		k: '{qtype: sqltp_pkg::QT_NONE, err: sqltp_pkg::ERR_NONE, tpos: '0, kpos: '0,
			vpos: '0, present: '0, cols: '0},
		pend: '0
	};

	function automatic logic [3:0] first_err(logic [3:0] cur, logic [3:0] code);
		return (cur == sqltp_pkg::ERR_NONE) ? code : cur;
	endfunction

	function automatic step_t check_state(step_t s, sqltp_pkg::tok_t t);
		step_t r;
		r = s;
		r.took = 1'b0;
		unique case (r.c.gs)
			G_CMD: begin
				if (t.kind == sqltp_pkg::K_SELECT) begin
					r.c.k.qtype = sqltp_pkg::QT_SELECT; r.c.gs = G_SEL_STAR; r.took = 1'b1;
				end else if (t.kind == sqltp_pkg::K_INSERT) begin
					r.c.k.qtype = sqltp_pkg::QT_INSERT; r.c.gs = G_INS_INTO; r.took = 1'b1;
				end else if (t.kind == sqltp_pkg::K_UPDATE) begin
					r.c.k.qtype = sqltp_pkg::QT_UPDATE; r.c.gs = G_UPD_TABLE; r.took = 1'b1;
				end else if (t.kind == sqltp_pkg::K_DELETE) begin
					r.c.k.qtype = sqltp_pkg::QT_DELETE; r.c.gs = G_DEL_FROM; r.took = 1'b1;
				end else if (t.kind == sqltp_pkg::K_CREATE) begin
					r.c.gs = G_CR_KIND; r.took = 1'b1;
				end else begin
					r.c.k.err = first_err(r.c.k.err, sqltp_pkg::ERR_UNKNOWN_CMD);
					r.c.gs = G_DONE;
				end
			end
			G_SEL_STAR: begin
				if (t.kind == sqltp_pkg::K_STAR) begin
					r.c.gs = G_SEL_FROM; r.took = 1'b1;
				end else begin
					r.c.k.err = first_err(r.c.k.err, sqltp_pkg::ERR_STAR); r.c.gs = G_DONE;
				end
			end
			G_SEL_FROM: begin
				if (t.kind == sqltp_pkg::K_FROM) begin
					r.c.gs = G_SEL_TABLE; r.took = 1'b1;
				end else begin
					r.c.k.err = first_err(r.c.k.err, sqltp_pkg::ERR_FROM); r.c.gs = G_DONE;
				end
			end
			G_SEL_TABLE: begin
				if (t.ident) begin
					r.c.k.tpos = t.pos; r.c.k.present[0] = 1'b1;
					r.c.gs = G_SEL_WHERE; r.took = 1'b1;
				end else begin
					r.c.k.err = first_err(r.c.k.err, sqltp_pkg::ERR_TABLE); r.c.gs = G_DONE;
				end
			end
			G_SEL_WHERE: begin
				if (t.kind == sqltp_pkg::K_WHERE) begin
					r.c.gs = G_SW_KEY; r.took = 1'b1;
				end else begin
					r.c.gs = G_DONE;
				end
			end
			G_SW_KEY: begin
				if (t.key_word) begin
					r.c.gs = G_SW_EQ; r.took = 1'b1;
				end else begin
					r.c.k.err = first_err(r.c.k.err, sqltp_pkg::ERR_KEY_WORD); r.c.gs = G_DONE;
				end
			end
			G_SW_EQ: begin
				if (t.kind == sqltp_pkg::K_EQ) begin
					r.c.gs = G_SW_VAL; r.took = 1'b1;
				end else begin
					r.c.k.err = first_err(r.c.k.err, sqltp_pkg::ERR_EQ); r.c.gs = G_DONE;
				end
			end
			G_SW_VAL: begin
				r.c.gs = G_DONE;
				if (t.value) begin
					r.c.k.kpos = t.pos; r.c.k.present[1] = 1'b1; r.took = 1'b1;
				end else begin
					r.c.k.err = first_err(r.c.k.err, sqltp_pkg::ERR_KEY_VALUE);
				end
			end
			G_INS_INTO: begin
				if (t.kind == sqltp_pkg::K_INTO) begin
					r.c.gs = G_INS_TABLE; r.took = 1'b1;
				end else begin
					r.c.k.err = first_err(r.c.k.err, sqltp_pkg::ERR_INTO); r.c.gs = G_DONE;
				end
			end
			G_INS_TABLE: begin
				r.c.gs = G_INS_COLS;
				if (t.ident) begin
					r.c.k.tpos = t.pos; r.c.k.present[0] = 1'b1; r.took = 1'b1;
				end
			end
			G_INS_COLS: begin
				if (t.kind == sqltp_pkg::K_LP) begin
					r.c.gs = G_INS_SKIP; r.took = 1'b1;
				end else begin
					r.c.gs = G_INS_VALUES;
				end
			end
			G_INS_SKIP: begin
				if (t.kind == sqltp_pkg::K_RP) begin
					r.c.gs = G_INS_VALUES; r.took = 1'b1;
				end else if (t.eof) begin
					r.c.gs = G_INS_VALUES;
				end else begin
					r.took = 1'b1;
				end
			end
			G_INS_VALUES: begin
				if (t.kind == sqltp_pkg::K_VALUES) begin
					r.c.gs = G_INS_LP; r.took = 1'b1;
				end else begin
					r.c.k.err = first_err(r.c.k.err, sqltp_pkg::ERR_VALUES); r.c.gs = G_DONE;
				end
			end
			G_INS_LP: begin
				if (t.kind == sqltp_pkg::K_LP) begin
					r.c.gs = G_INS_KEY; r.took = 1'b1;
				end else begin
					r.c.gs = G_DONE;
				end
			end
			G_INS_KEY: begin
				r.c.gs = G_INS_COMMA;
				if (t.value) begin
					r.c.k.kpos = t.pos; r.c.k.present[1] = 1'b1; r.took = 1'b1;
				end
			end
			G_INS_COMMA: begin
				if (t.kind == sqltp_pkg::K_COMMA) begin
					r.c.gs = G_INS_VAL; r.took = 1'b1;
				end else begin
					r.c.gs = G_INS_RP;
				end
			end
			G_INS_VAL: begin
				r.c.gs = G_INS_RP;
				if (t.value) begin
					r.c.k.vpos = t.pos; r.c.k.present[2] = 1'b1; r.took = 1'b1;
				end
			end
			G_INS_RP: begin
				r.c.gs = G_DONE;
				r.took = (t.kind == sqltp_pkg::K_RP);
			end
			G_UPD_TABLE: begin
				r.c.gs = G_UPD_SET;
				if (t.ident) begin
					r.c.k.tpos = t.pos; r.c.k.present[0] = 1'b1; r.took = 1'b1;
				end
			end
			G_UPD_SET: begin
				if (t.kind == sqltp_pkg::K_SET) begin
					r.c.gs = G_US_WORD; r.took = 1'b1;
				end else begin
					r.c.gs = G_WHERE;
				end
			end
			G_US_WORD: begin
				if (t.val_word) begin
					r.c.gs = G_US_EQ; r.took = 1'b1;
				end else begin
					r.c.gs = G_WHERE;
				end
			end
			G_US_EQ: begin
				if (t.kind == sqltp_pkg::K_EQ) begin
					r.c.gs = G_US_VAL; r.took = 1'b1;
				end else begin
					r.c.gs = G_WHERE;
				end
			end
			G_US_VAL: begin
				r.c.gs = G_WHERE;
				if (t.value) begin
					r.c.k.vpos = t.pos; r.c.k.present[2] = 1'b1; r.took = 1'b1;
				end
			end
			G_DEL_FROM: begin
				if (t.kind == sqltp_pkg::K_FROM) begin
					r.c.gs = G_DEL_TABLE; r.took = 1'b1;
				end else begin
					r.c.gs = G_WHERE;
				end
			end
			G_DEL_TABLE: begin
				r.c.gs = G_WHERE;
				if (t.ident) begin
					r.c.k.tpos = t.pos; r.c.k.present[0] = 1'b1; r.took = 1'b1;
				end
			end
			G_WHERE: begin
				if (t.kind == sqltp_pkg::K_WHERE) begin
					r.c.gs = G_W_KEY; r.took = 1'b1;
				end else begin
					r.c.gs = G_DONE;
				end
			end
			G_W_KEY: begin
				if (t.key_word) begin
					r.c.gs = G_W_EQ; r.took = 1'b1;
				end else begin
					r.c.gs = G_DONE;
				end
			end
			G_W_EQ: begin
				if (t.kind == sqltp_pkg::K_EQ) begin
					r.c.gs = G_W_VAL; r.took = 1'b1;
				end else begin
					r.c.gs = G_DONE;
				end
			end
			G_W_VAL: begin
				r.c.gs = G_DONE;
				if (t.value) begin
					r.c.k.kpos = t.pos; r.c.k.present[1] = 1'b1; r.took = 1'b1;
				end
			end
			G_CR_KIND: begin
				if (t.kind == sqltp_pkg::K_DATABASE) begin
					r.c.k.qtype = sqltp_pkg::QT_CREATEDB; r.c.gs = G_CR_DB; r.took = 1'b1;
				end else if (t.kind == sqltp_pkg::K_TABLE) begin
					r.c.k.qtype = sqltp_pkg::QT_CREATETB; r.c.gs = G_CT_NAME; r.took = 1'b1;
				end else begin
					r.c.k.err = first_err(r.c.k.err, sqltp_pkg::ERR_CREATE_KIND);
					r.c.gs = G_DONE;
				end
			end
			G_CR_DB: begin
				r.c.gs = G_DONE;
				if (t.ident) begin
					r.c.k.kpos = t.pos; r.c.k.present[1] = 1'b1; r.took = 1'b1;
				end else begin
					r.c.k.err = first_err(r.c.k.err, sqltp_pkg::ERR_DB_NAME);
				end
			end
			G_CT_NAME: begin
				r.c.gs = G_CT_LP;
				if (t.ident) begin
					r.c.k.tpos = t.pos; r.c.k.present[0] = 1'b1; r.took = 1'b1;
				end else begin
					r.c.k.err = first_err(r.c.k.err, sqltp_pkg::ERR_TABLE);
				end
			end
			G_CT_LP: begin
				if (t.kind == sqltp_pkg::K_LP) begin
					r.c.gs = G_CT_COL; r.took = 1'b1;
				end else begin
					r.c.gs = G_DONE;
				end
			end
			G_CT_COL: begin
				if (t.ident) begin
					r.c.pend.name = t.pos; r.c.pend.ctype = sqltp_pkg::COLT_UNSET;
					r.c.pend.nn = 1'b0;
					r.c.gs = G_CT_TYPE; r.took = 1'b1;
				end else begin
					r.c.gs = G_CT_RP;
				end
			end
			G_CT_TYPE: begin
				if (t.kind == sqltp_pkg::K_INT) begin
					r.c.pend.ctype = sqltp_pkg::COLT_INT; r.c.gs = G_CT_NN; r.took = 1'b1;
				end else if (t.kind == sqltp_pkg::K_VARCHAR) begin
					r.c.pend.ctype = sqltp_pkg::COLT_VARCHAR; r.c.gs = G_CT_VLP;
					r.took = 1'b1;
				end else begin
					r.c.gs = G_CT_NN;
				end
			end
			G_CT_VLP: begin
				if (t.kind == sqltp_pkg::K_LP) begin
					r.c.gs = G_CT_VSIZE; r.took = 1'b1;
				end else begin
					r.c.gs = G_CT_NN;
				end
			end
			G_CT_VSIZE: begin
				r.c.gs = G_CT_VRP; r.took = 1'b1;
			end
			G_CT_VRP: begin
				r.c.gs = G_CT_NN;
				r.took = (t.kind == sqltp_pkg::K_RP);
			end
			G_CT_NN: begin
				r.c.gs = G_CT_COMMA;
				if (t.kind == sqltp_pkg::K_NOTNULL) begin
					r.c.pend.nn = 1'b1; r.took = 1'b1;
				end
				if (r.c.k.cols != 8'hFF) begin
					r.c.k.cols = r.c.k.cols + 8'd1;
				end
				r.fire = 1'b1;
				r.col = r.c.pend;
				r.c.pend = '0;
			end
			G_CT_COMMA: begin
				if (t.kind == sqltp_pkg::K_COMMA) begin
					r.c.gs = G_CT_COL; r.took = 1'b1;
				end else begin
					r.c.gs = G_CT_RP;
				end
			end
			G_CT_RP: begin
				r.c.gs = G_DONE;
				r.took = (t.kind == sqltp_pkg::K_RP);
			end
			default: begin
				r.c.gs = G_DONE;
			end
		endcase
		return r;
	endfunction

	// A token that is not taken falls through to the next grammar state; EOF walks to the end.
	function automatic step_t run_chain(ctx_t c, sqltp_pkg::tok_t t);
		step_t s;
		logic  stop;
		s.c = c;
		s.col = '0;
		s.fire = 1'b0;
		s.took = 1'b0;
		stop = 1'b0;
		for (int i = 0; i < CHAIN_STEPS; i++) begin
			if (!stop && s.c.gs != G_DONE) begin
				s = check_state(s, t);
				if (s.took && !t.eof) begin
					stop = 1'b1;
				end
			end
		end
		return s;
	endfunction

	ctx_t  ctx_q;
	kept_t snap_q;
	col_t  col_q;
	logic  out_valid_q;
	logic  has_col_q;
	logic  has_query_q;
	logic  col_sent_q;
	step_t step;
	logic  has_res;
	logic  show_col;
	logic  rec_xfer;
	logic  slot_free;

	assign step = run_chain(ctx_q, head);
	assign has_res = step.fire || head.eof;
	assign show_col = has_col_q && !col_sent_q;
	assign rec_xfer = records.valid && records.ready;
	assign slot_free = !out_valid_q || (rec_xfer && records.last);
	assign pop = head_valid && (!has_res || slot_free);

	assign records.valid = out_valid_q;
	assign records.record_kind = show_col ? sqltp_pkg::REC_COLUMN : sqltp_pkg::REC_QUERY;
	assign records.query_type = $signed(snap_q.qtype);
	assign records.error_code = snap_q.err;
	assign records.table_pos = snap_q.tpos;
	assign records.key_pos = snap_q.kpos;
	assign records.val_pos = snap_q.vpos;
	assign records.present_mask = snap_q.present;
	assign records.column_count = snap_q.cols;
	assign records.column_name_pos = show_col ? col_q.name : '0;
	assign records.column_type = show_col ? col_q.ctype : sqltp_pkg::COLT_UNSET;
	assign records.column_not_null = show_col && col_q.nn;
	assign records.last = !show_col || !has_query_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= CTX_RESET;
			snap_q <= CTX_RESET.k;
			col_q <= '0;
			out_valid_q <= 1'b0;
			has_col_q <= 1'b0;
			has_query_q <= 1'b0;
			col_sent_q <= 1'b0;
		end else begin
			if (pop) begin
				ctx_q <= head.eof ? CTX_RESET : step.c;
			end
			if (pop && has_res) begin
				out_valid_q <= 1'b1;
				col_sent_q <= 1'b0;
				has_col_q <= step.fire;
				has_query_q <= head.eof;
				snap_q <= step.c.k;
				col_q <= step.col;
			end else if (rec_xfer) begin
				if (records.last) begin
					out_valid_q <= 1'b0;
				end else begin
					col_sent_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== src/sqltp_checker.sv =====
// Port-level checks of the SQL token parser and their binding to the top level.
module sqltp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              rec_valid,
	input logic              rec_ready,
	input logic              record_kind,
	input logic signed [3:0] query_type,
	input logic [7:0]        column_count,
	input logic [11:0]       column_name_pos,
	input logic [1:0]        column_type,
	input logic              column_not_null,
	input logic              last
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_ready |=> rec_valid && $stable(record_kind) && $stable(last)
			&& $stable(column_name_pos))
		else $error("record changed while stalled");

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !rec_valid)
		else $error("record valid during reset");

	a_query_last: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && record_kind |-> last && column_name_pos == 12'd0 && column_type == 2'd0
			&& !column_not_null)
		else $error("query record is not last or carries column fields");

	a_column_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !record_kind |-> query_type == 4'sd5 && column_count != 8'd0)
		else $error("column record outside create table");

endmodule

bind sql_statement_token_parser sqltp_checker u_sqltp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rec_valid       (records.valid),
	.rec_ready       (records.ready),
	.record_kind     (records.record_kind),
	.query_type      (records.query_type),
	.column_count    (records.column_count),
	.column_name_pos (records.column_name_pos),
	.column_type     (records.column_type),
	.column_not_null (records.column_not_null),
	.last            (records.last)
);
